// File: src/lffd_pkg.sv
package lffd_pkg;

	localparam int DATA_W = 8;
	localparam int POS_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_PAYLOAD = 3'd0;
	localparam kind_t KIND_EMPTY = 3'd1;
	localparam kind_t KIND_TOO_SMALL = 3'd2;
	localparam kind_t KIND_TOO_LARGE = 3'd3;
	localparam kind_t KIND_STRIP_ERR = 3'd4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_FIELD_BYTES = 3'd0;
	localparam cfg_idx_t CFG_FIELD_OFFSET = 3'd1;
	localparam cfg_idx_t CFG_ADJUST = 3'd2;
	localparam cfg_idx_t CFG_STRIP = 3'd3;
	localparam cfg_idx_t CFG_MAX_LEN = 3'd4;
	localparam cfg_idx_t CFG_BIG_ENDIAN = 3'd5;

	localparam logic [3:0] RST_FIELD_BYTES = 4'd4;
	localparam logic [3:0] RST_FIELD_OFFSET = 4'd0;
	localparam logic [31:0] RST_ADJUST = 32'd0;
	localparam logic [31:0] RST_STRIP = 32'd0;
	localparam logic [31:0] RST_MAX_LEN = 32'd65536;
	localparam logic RST_BIG_ENDIAN = 1'b1;

	// which result the output register loads
	typedef logic [1:0] src_t;

	localparam src_t SRC_SMALL = 2'd0;
	localparam src_t SRC_LARGE = 2'd1;
	localparam src_t SRC_FB_MEM = 2'd2;
	localparam src_t SRC_FB_IN = 2'd3;

	typedef struct packed {
		logic hdr_wr;
		logic fld_start;
		logic fld_run;
		logic adj_calc;
		logic tot_calc;
		logic pos_clr;
		logic pos_set_hend;
		logic pos_inc;
		logic rd_issue;
		logic emit;
		src_t src;
	} cmd_t;

	typedef struct packed {
		logic hdr_last;
		logic fld_done;
		logic too_small;
		logic too_large;
		logic total_gt_hend;
		logic fb_emit;
		logic pos_last;
		logic rpl_last;
		logic out_free;
	} sts_t;

endpackage

// File: src/lffd_if.sv
interface lffd_in_if import lffd_pkg::*; ();
	logic valid;
	logic ready;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface lffd_out_if import lffd_pkg::*; ();
	logic valid;
	logic ready;
	kind_t kind;
	logic [DATA_W-1:0] payload;
	logic frame_first;
	logic frame_last;
	logic run_last;

	modport source (output valid, output kind, output payload, output frame_first,
		output frame_last, output run_last, input ready);
	modport sink (input valid, input kind, input payload, input frame_first,
		input frame_last, input run_last, output ready);
endinterface

// File: src/lffd_datapath.sv
module lffd_datapath import lffd_pkg::*; #(
	parameter int HEADER_BYTES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [DATA_W-1:0]     data_byte,
	input  logic                  out_ready,
	output logic                  out_valid,
	output kind_t                 kind,
	output logic [DATA_W-1:0]     payload,
	output logic                  frame_first,
	output logic                  frame_last,
	output logic                  run_last
);

	localparam int AW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
	localparam int HW = $clog2(HEADER_BYTES + 1);
	// wide enough for offset plus width and for the header size
	localparam int SW = $clog2(HEADER_BYTES + 24);
	localparam int W_CAP = (HEADER_BYTES >= 8) ? 8 : ((HEADER_BYTES >= 4) ? 4 : 2);

	logic [3:0] lfb_q;
	logic [3:0] lfo_q;
	logic [31:0] adj_q;
	logic [31:0] strip_q;
	logic [31:0] max_q;
	logic big_q;

	logic [3:0] w_raw;
	logic [3:0] w_sel;
	logic [SW-1:0] off_ext;
	logic [SW-1:0] w_ext;
	logic [SW-1:0] off_sel;
	logic [HW-1:0] hend;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_nxt;

	logic [DATA_W-1:0] store_mem [HEADER_BYTES];
	logic [DATA_W-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic rd_en;

	logic [3:0] k_q;
	logic k_lt_w;
	logic rdv_s1;
	logic [2:0] kk_s1;
	logic [POS_W-1:0] field_q;

	logic [31:0] mag;
	logic small_c;
	logic [POS_W:0] asum;
	logic [POS_W-1:0] base_c;
	logic [POS_W-1:0] base_q;
	logic small_q;
	logic [POS_W:0] tsum;
	logic [POS_W-1:0] total_q;

	logic pos_ge_strip;
	logic pos_eq_strip;
	logic strip_eq_nxt;
	kind_t fb_kind;
	logic fb_first;

	logic out_valid_q;
	kind_t kind_q;
	logic [DATA_W-1:0] payload_q;
	logic first_q;
	logic last_q;
	logic run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_q <= RST_FIELD_BYTES;
			lfo_q <= RST_FIELD_OFFSET;
			adj_q <= RST_ADJUST;
			strip_q <= RST_STRIP;
			max_q <= RST_MAX_LEN;
			big_q <= RST_BIG_ENDIAN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIELD_BYTES: lfb_q <= cfg_data[3:0];
				CFG_FIELD_OFFSET: lfo_q <= cfg_data[3:0];
				CFG_ADJUST: adj_q <= cfg_data;
				CFG_STRIP: strip_q <= cfg_data;
				CFG_MAX_LEN: max_q <= cfg_data;
				CFG_BIG_ENDIAN: big_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// field width rounded down to a power of two and capped to the header size, then the offset pulled in to fit
	always_comb begin
		if (lfb_q >= 4'd8) begin
			w_raw = 4'd8;
		end else if (lfb_q >= 4'd4) begin
			w_raw = 4'd4;
		end else if (lfb_q >= 4'd2) begin
			w_raw = 4'd2;
		end else begin
			w_raw = 4'd1;
		end
		w_sel = (w_raw > 4'(W_CAP)) ? 4'(W_CAP) : w_raw;
		off_ext = SW'(lfo_q);
		w_ext = SW'(w_sel);
		if (off_ext + w_ext > SW'(HEADER_BYTES)) begin
			off_sel = SW'(HEADER_BYTES) - w_ext;
		end else begin
			off_sel = off_ext;
		end
		hend = HW'(off_sel + w_ext);
	end

	assign pos_nxt = pos_q + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.pos_clr) begin
			pos_q <= '0;
		end else if (cmd.pos_set_hend) begin
			pos_q <= POS_W'(hend);
		end else if (cmd.pos_inc) begin
			pos_q <= pos_nxt;
		end
	end

	// header store, one read port with registered data
	assign k_lt_w = k_q < w_sel;
	assign rd_en = cmd.rd_issue | (cmd.fld_run & k_lt_w);
	assign raddr = cmd.rd_issue ? pos_q[AW-1:0] : AW'(off_sel + SW'(k_q));

	always_ff @(posedge clk) begin
		if (cmd.hdr_wr) begin
			store_mem[pos_q[AW-1:0]] <= data_byte;
		end
		if (rd_en) begin
			rdata_q <= store_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			rdv_s1 <= 1'b0;
			kk_s1 <= '0;
		end else if (cmd.fld_start) begin
			k_q <= '0;
			rdv_s1 <= 1'b0;
		end else if (cmd.fld_run) begin
			rdv_s1 <= k_lt_w;
			kk_s1 <= k_q[2:0];
			if (k_lt_w) begin
				k_q <= k_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fld_start) begin
			field_q <= '0;
		end else if (cmd.fld_run && rdv_s1) begin
			if (big_q) begin
				field_q <= {field_q[POS_W-DATA_W-1:0], rdata_q};
			end else begin
				field_q[{kk_s1, 3'b000} +: DATA_W] <= rdata_q;
			end
		end
	end

	// field plus signed adjustment, saturating upward and flagging a result below zero; total adds the header end
	always_comb begin
		mag = ~adj_q + 32'd1;
		small_c = adj_q[31] && (field_q < POS_W'(mag));
		asum = {1'b0, field_q} + (POS_W + 1)'(adj_q);
		if (adj_q[31]) begin
			base_c = field_q - POS_W'(mag);
		end else if (asum[POS_W]) begin
			base_c = '1;
		end else begin
			base_c = asum[POS_W-1:0];
		end
		tsum = {1'b0, base_q} + (POS_W + 1)'(hend);
	end

	always_ff @(posedge clk) begin
		if (cmd.adj_calc) begin
			base_q <= base_c;
			small_q <= small_c;
		end
		if (cmd.tot_calc) begin
			total_q <= tsum[POS_W] ? '1 : tsum[POS_W-1:0];
		end
	end

	// per-byte delivery decision
	always_comb begin
		pos_ge_strip = pos_q >= POS_W'(strip_q);
		pos_eq_strip = pos_q == POS_W'(strip_q);
		strip_eq_nxt = pos_nxt == POS_W'(strip_q);
		sts.hdr_last = pos_nxt >= POS_W'(hend);
		sts.fld_done = rdv_s1 && ({1'b0, kk_s1} == w_sel - 4'd1);
		sts.too_small = small_q;
		sts.too_large = total_q > POS_W'(max_q);
		sts.total_gt_hend = total_q > POS_W'(hend);
		sts.pos_last = pos_nxt == total_q;
		sts.rpl_last = pos_nxt == POS_W'(hend);
		sts.fb_emit = sts.pos_last || pos_ge_strip;
		sts.out_free = !out_valid_q || out_ready;
		if (sts.pos_last && !pos_ge_strip) begin
			fb_kind = strip_eq_nxt ? KIND_EMPTY : KIND_STRIP_ERR;
			fb_first = strip_eq_nxt;
		end else begin
			fb_kind = KIND_PAYLOAD;
			fb_first = pos_eq_strip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.src)
				SRC_SMALL: begin
					kind_q <= KIND_TOO_SMALL;
					payload_q <= '0;
					first_q <= 1'b0;
					last_q <= 1'b1;
					run_last_q <= 1'b1;
				end
				SRC_LARGE: begin
					kind_q <= KIND_TOO_LARGE;
					payload_q <= '0;
					first_q <= 1'b0;
					last_q <= 1'b1;
					run_last_q <= 1'b1;
				end
				SRC_FB_MEM: begin
					kind_q <= fb_kind;
					payload_q <= (fb_kind == KIND_PAYLOAD) ? rdata_q : '0;
					first_q <= fb_first;
					last_q <= sts.pos_last;
					run_last_q <= sts.rpl_last;
				end
				SRC_FB_IN: begin
					kind_q <= fb_kind;
					payload_q <= (fb_kind == KIND_PAYLOAD) ? data_byte : '0;
					first_q <= fb_first;
					last_q <= sts.pos_last;
					run_last_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign payload = payload_q;
	assign frame_first = first_q;
	assign frame_last = last_q;
	assign run_last = run_last_q;

endmodule

// File: src/lffd_ctrl.sv
module lffd_ctrl import lffd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_HDR = 4'd0;
	localparam logic [3:0] S_FLD = 4'd1;
	localparam logic [3:0] S_ADJ = 4'd2;
	localparam logic [3:0] S_TOT = 4'd3;
	localparam logic [3:0] S_CHK = 4'd4;
	localparam logic [3:0] S_RRD = 4'd5;
	localparam logic [3:0] S_RPL = 4'd6;
	localparam logic [3:0] S_STR = 4'd7;
	localparam logic [3:0] S_DIS = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.src = SRC_SMALL;
		in_ready = 1'b0;
		case (state_q)
			S_HDR: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.hdr_wr = 1'b1;
					cmd.pos_inc = 1'b1;
					if (sts.hdr_last) begin
						cmd.fld_start = 1'b1;
						state_d = S_FLD;
					end
				end
			end
			S_FLD: begin
				cmd.fld_run = 1'b1;
				if (sts.fld_done) begin
					state_d = S_ADJ;
				end
			end
			S_ADJ: begin
				cmd.adj_calc = 1'b1;
				state_d = S_TOT;
			end
			S_TOT: begin
				cmd.tot_calc = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.out_free) begin
					if (sts.too_small) begin
						cmd.emit = 1'b1;
						cmd.src = SRC_SMALL;
						cmd.pos_clr = 1'b1;
						state_d = S_HDR;
					end else if (sts.too_large) begin
						cmd.emit = 1'b1;
						cmd.src = SRC_LARGE;
						if (sts.total_gt_hend) begin
							cmd.pos_set_hend = 1'b1;
							state_d = S_DIS;
						end else begin
							cmd.pos_clr = 1'b1;
							state_d = S_HDR;
						end
					end else begin
						cmd.pos_clr = 1'b1;
						state_d = S_RRD;
					end
				end
			end
			S_RRD: begin
				cmd.rd_issue = 1'b1;
				state_d = S_RPL;
			end
			S_RPL: begin
				if (sts.out_free || !sts.fb_emit) begin
					cmd.emit = sts.fb_emit;
					cmd.src = SRC_FB_MEM;
					if (sts.rpl_last && sts.pos_last) begin
						cmd.pos_clr = 1'b1;
						state_d = S_HDR;
					end else begin
						cmd.pos_inc = 1'b1;
						state_d = sts.rpl_last ? S_STR : S_RRD;
					end
				end
			end
			S_STR: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					cmd.emit = sts.fb_emit;
					cmd.src = SRC_FB_IN;
					if (sts.pos_last) begin
						cmd.pos_clr = 1'b1;
						state_d = S_HDR;
					end else begin
						cmd.pos_inc = 1'b1;
					end
				end
			end
			S_DIS: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.pos_last) begin
						cmd.pos_clr = 1'b1;
						state_d = S_HDR;
					end else begin
						cmd.pos_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_HDR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HDR;
		end else begin
			state_q <= state_d;
		end
	end

	// never load the output register over a word still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output word pending");

	a_ready_states: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_HDR || state_q == S_STR || state_q == S_DIS))
		else $error("input taken during header processing");

	a_fld_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.fld_done |-> state_q == S_FLD)
		else $error("field read finished outside field phase");

	a_fld_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fld_start |=> (state_q == S_FLD && !sts.fld_done))
		else $error("field read did not restart cleanly");

	a_hdr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hdr_wr |-> !cmd.emit)
		else $error("header byte produced a result");

endmodule

// File: src/length_field_frame_deframer_core.sv
// header bytes: one per cycle, no result until the length field completes
// header end: the field is read, adjusted, totalled and checked (S_FLD, S_ADJ, S_TOT,
//   S_CHK); a frame in range then replays its header through the single store read port
// stream: a byte per cycle while the output is free, result valid the cycle after; discard: a byte per cycle, no result
// reset (arst_n low): control, config, position and output valid to defaults; header store and data not cleared
module length_field_frame_deframer_core import lffd_pkg::*; #(
	parameter int HEADER_BYTES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lffd_in_if.sink               stream,
	lffd_out_if.source            result,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	lffd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (stream.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lffd_datapath #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (stream.data_byte),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.kind        (result.kind),
		.payload     (result.payload),
		.frame_first (result.frame_first),
		.frame_last  (result.frame_last),
		.run_last    (result.run_last)
	);

endmodule

// File: tb/tb_length_field_frame_deframer_core.sv
module tb_length_field_frame_deframer_core;
	import lffd_pkg::*;

	localparam int HDR_DEPTH = 16;
	localparam int SETTLE = 80;
	localparam int LONG_HOLD = 400;
	localparam int LIMIT = 1000000;
	localparam int PHASE_BYTES = 6;

	typedef enum logic [1:0] {GATHER, RELAY, SKIP} deframe_phase_e;

	typedef struct packed {
		kind_t kind;
		logic [7:0] payload;
		logic first;
		logic last;
		logic run_end;
	} deframe_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lffd_in_if stream_bus();
	lffd_out_if result_bus();

	length_field_frame_deframer_core #(.HEADER_BYTES(HDR_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_bus),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// register settings as last written
	logic [3:0] set_width;
	logic [3:0] set_offset;
	logic signed [31:0] set_adjust;
	logic [31:0] set_strip;
	logic [31:0] set_max;
	logic set_big;

	// deframer state as predicted
	deframe_phase_e dphase;
	logic [7:0] hdr_mem [HDR_DEPTH];
	logic [63:0] frame_pos;
	logic [63:0] frame_len;

	deframe_word_t step_words[$];
	deframe_word_t expected_words[$];
	logic [7:0] send_q[$];

	int bytes_queued = 0;
	int bytes_taken = 0;
	int errors = 0;
	int ticks = 0;
	int holds_asked = 0;
	int holds_served = 0;
	bit calm = 1'b0;

	function automatic int eff_width(logic [3:0] sel);
		if (sel >= 8) return 8;
		if (sel >= 4) return 4;
		if (sel >= 2) return 2;
		return 1;
	endfunction

	function automatic int eff_offset(int w, logic [3:0] sel);
		return (int'(sel) + w > HDR_DEPTH) ? HDR_DEPTH - w : int'(sel);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void note_word(kind_t kind, logic [7:0] payload, logic first, logic last);
		deframe_word_t w;
		w.kind = kind;
		w.payload = payload;
		w.first = first;
		w.last = last;
		w.run_end = 1'b0;
		step_words.push_back(w);
	endfunction

	function automatic void frame_word(logic [63:0] p, logic [7:0] b);
		logic [63:0] strip;
		strip = {32'b0, set_strip};
		if (p + 64'd1 == frame_len) begin
			if (strip < frame_len) note_word(KIND_PAYLOAD, b, p == strip, 1'b1);
			else if (strip == frame_len) note_word(KIND_EMPTY, 8'h00, 1'b1, 1'b1);
			else note_word(KIND_STRIP_ERR, 8'h00, 1'b0, 1'b1);
		end else if (p >= strip) begin
			note_word(KIND_PAYLOAD, b, p == strip, 1'b0);
		end
	endfunction

	// length field complete: size the frame, then, if it is in range, replay the buffered header
	function automatic void close_header(int w, int off, int hend);
		logic [63:0] field;
		logic [63:0] base;
		logic [63:0] total;
		logic [63:0] mag;
		logic [31:0] neg;
		field = '0;
		for (int k = 0; k < w; k++) begin
			if (set_big) field = (field << 8) | {56'b0, hdr_mem[(off + k) % HDR_DEPTH]};
			else field = field | ({56'b0, hdr_mem[(off + k) % HDR_DEPTH]} << (8 * k));
		end
		if (set_adjust[31]) begin
			neg = ~set_adjust + 32'd1;
			mag = {32'b0, neg};
			if (field < mag) begin
				note_word(KIND_TOO_SMALL, 8'h00, 1'b0, 1'b1);
				frame_pos = '0;
				return;
			end
			base = field - mag;
		end else begin
			base = field + {32'b0, set_adjust};
			if (base < field) base = '1;
		end
		total = base + 64'(hend);
		if (total < base) total = '1;
		frame_len = total;
		if (total > {32'b0, set_max}) begin
			note_word(KIND_TOO_LARGE, 8'h00, 1'b0, 1'b1);
			if (total > 64'(hend)) begin
				dphase = SKIP;
				frame_pos = 64'(hend);
			end else begin
				frame_pos = '0;
			end
			return;
		end
		for (int i = 0; i < hend; i++) frame_word(64'(i), hdr_mem[i]);
		if (total > 64'(hend)) begin
			dphase = RELAY;
			frame_pos = 64'(hend);
		end else begin
			frame_pos = '0;
		end
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		int w;
		int off;
		step_words.delete();
		case (dphase)
			RELAY: begin
				frame_word(frame_pos, b);
				frame_pos++;
				if (frame_pos >= frame_len) begin
					dphase = GATHER;
					frame_pos = '0;
				end
			end
			SKIP: begin
				frame_pos++;
				if (frame_pos >= frame_len) begin
					dphase = GATHER;
					frame_pos = '0;
				end
			end
			default: begin
				w = eff_width(set_width);
				off = eff_offset(w, set_offset);
				if (frame_pos < HDR_DEPTH) hdr_mem[frame_pos] = b;
				frame_pos++;
				if (frame_pos >= 64'(off + w)) close_header(w, off, off + w);
			end
		endcase
		if (step_words.size() > 0) step_words[step_words.size() - 1].run_end = 1'b1;
		foreach (step_words[i]) expected_words.push_back(step_words[i]);
	endfunction

	function automatic void queue_byte(logic [7:0] b);
		send_q.push_back(b);
		bytes_queued++;
	endfunction

	// one frame under the current settings; runt, under a negative adjustment, gives a negative frame length
	function automatic int add_frame(bit runt);
		int w;
		int off;
		int hend;
		int body;
		longint adj;
		logic [63:0] fld;
		logic [63:0] fld_max;
		logic [63:0] span;
		logic [7:0] hdr [HDR_DEPTH];
		w = eff_width(set_width);
		off = eff_offset(w, set_offset);
		hend = off + w;
		adj = set_adjust;
		fld_max = (w >= 8) ? '1 : (64'd1 << (8 * w)) - 64'd1;
		for (int i = 0; i < hend; i++) hdr[i] = 8'($urandom);
		if (runt && adj < 0) begin
			span = 64'(-adj - 1);
			if (span > fld_max) span = fld_max;
			fld = {$urandom, $urandom} % (span + 64'd1);
			body = 0;
		end else begin
			fld = 64'((adj < 0) ? -adj : 0) + 64'($urandom_range(0, 12));
			body = int'(longint'(fld) + adj);
		end
		for (int k = 0; k < w; k++) begin
			if (set_big) hdr[off + k] = 8'(fld >> (8 * (w - 1 - k)));
			else hdr[off + k] = 8'(fld >> (8 * k));
		end
		for (int i = 0; i < hend; i++) queue_byte(hdr[i]);
		for (int i = 0; i < body; i++) queue_byte(8'($urandom));
		return hend + body;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic load_setup(logic [3:0] width_sel, logic [3:0] offset_sel, logic [31:0] adjust,
		logic [31:0] strip, logic [31:0] max_len, logic big);
		write_reg(CFG_FIELD_BYTES, {28'b0, width_sel});
		write_reg(CFG_FIELD_OFFSET, {28'b0, offset_sel});
		write_reg(CFG_ADJUST, adjust);
		write_reg(CFG_STRIP, strip);
		write_reg(CFG_MAX_LEN, max_len);
		write_reg(CFG_BIG_ENDIAN, {31'b0, big});
		@(posedge clk);
		cfg_we <= 1'b0;
		set_width = width_sel;
		set_offset = offset_sel;
		set_adjust = adjust;
		set_strip = strip;
		set_max = max_len;
		set_big = big;
	endtask

	// sender stops until every word is back and the block has gone quiet
	task automatic drain();
		while (bytes_taken != bytes_queued || expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// byte driver
	bit offer;
	logic [7:0] next_byte;
	int send_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_bus.valid <= 1'b0;
			stream_bus.data_byte <= '0;
			send_wait = 0;
		end else begin
			offer = stream_bus.valid;
			next_byte = stream_bus.data_byte;
			if (stream_bus.valid && stream_bus.ready) begin
				predict_byte(stream_bus.data_byte);
				bytes_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (send_q.size() > 0) begin
					next_byte = send_q.pop_front();
					offer = 1'b1;
					send_wait = pick_gap();
				end
			end
			stream_bus.valid <= offer;
			stream_bus.data_byte <= next_byte;
		end
	end

	// result monitor
	bit take;
	int take_wait;
	int hold_left;
	deframe_word_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			take_wait = 0;
			hold_left = 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_words.size() == 0) begin
					$error("word with nothing expected: kind %0d payload %0h",
						result_bus.kind, result_bus.payload);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (result_bus.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result_bus.kind);
						errors++;
					end
					if (result_bus.payload !== want.payload) begin
						$error("payload: expected %0h, got %0h", want.payload, result_bus.payload);
						errors++;
					end
					if (result_bus.frame_first !== want.first) begin
						$error("frame_first: expected %0b, got %0b", want.first,
							result_bus.frame_first);
						errors++;
					end
					if (result_bus.frame_last !== want.last) begin
						$error("frame_last: expected %0b, got %0b", want.last, result_bus.frame_last);
						errors++;
					end
					if (result_bus.run_last !== want.run_end) begin
						$error("run_last: expected %0b, got %0b", want.run_end, result_bus.run_last);
						errors++;
					end
				end
				take_wait = pick_gap();
			end
			if (holds_served < holds_asked) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (take_wait > 0) begin
				take_wait--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			result_bus.ready <= take;
		end
	end

	always @(posedge clk) begin
		ticks++;
		if (ticks == LIMIT) begin
			$display("tb_length_field_frame_deframer_core NOT OK");
			$finish;
		end
	end

	initial begin
		logic [3:0] width_sel;
		logic [3:0] offset_sel;
		logic [31:0] adjust;
		logic [31:0] strip;
		logic [31:0] max_len;
		logic big;
		int hend;
		int phase_bytes;

		stream_bus.valid = 1'b0;
		stream_bus.data_byte = '0;
		result_bus.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIELD_BYTES;
		cfg_data = '0;
		set_width = RST_FIELD_BYTES;
		set_offset = RST_FIELD_OFFSET;
		set_adjust = RST_ADJUST;
		set_strip = RST_STRIP;
		set_max = RST_MAX_LEN;
		set_big = RST_BIG_ENDIAN;
		dphase = GATHER;
		frame_pos = '0;
		frame_len = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one-byte field: plain frame carrying the byte extremes
		load_setup(4'd1, 4'd0, 32'd0, 32'd0, '1, 1'b1);
		queue_byte(8'h02);
		queue_byte(8'h00);
		queue_byte(8'hff);
		drain();

		// negative adjustment: too small, empty frame, stripped frame
		load_setup(4'd1, 4'd0, '1, 32'd1, '1, 1'b0);
		queue_byte(8'h00);
		queue_byte(8'h01);
		queue_byte(8'h03);
		queue_byte(8'ha5);
		queue_byte(8'h5a);
		drain();

		// strip past the frame end
		load_setup(4'd1, 4'd0, '1, 32'd2, '1, 1'b0);
		queue_byte(8'h01);
		drain();

		// too large with a discarded body, then zero max length
		load_setup(4'd1, 4'd0, '1, 32'd0, 32'd2, 1'b1);
		queue_byte(8'h04);
		queue_byte(8'h11);
		queue_byte(8'h22);
		queue_byte(8'h33);
		drain();
		load_setup(4'd1, 4'd0, '1, 32'd0, 32'd0, 1'b1);
		queue_byte(8'h01);
		drain();

		for (int p = 0; p < 5; p++) begin
			width_sel = 4'($urandom_range(0, 15));
			if (p == 1 && eff_width(width_sel) < 4) width_sel = 4'($urandom_range(4, 15));
			offset_sel = 4'($urandom_range(0, 15));
			adjust = $urandom_range(0, 12) - 6;
			if (p == 1) adjust = 32'h8000_0000;
			strip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
			if (p == 0) strip = '1;
			hend = eff_offset(eff_width(width_sel), offset_sel) + eff_width(width_sel);
			max_len = '1;
			if (p == 2 || $urandom_range(0, 3) == 0) max_len = hend + $urandom_range(0, 12);
			big = 1'($urandom_range(0, 1));
			calm = (p == 3);
			load_setup(width_sel, offset_sel, adjust, strip, max_len, big);
			// receiver sits still while the sender keeps pushing
			if (p == 2) holds_asked++;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) phase_bytes += add_frame($urandom_range(0, 4) == 0);
			drain();
		end
		calm = 1'b0;

		// invalid width and field past the header; all-ones field with the largest
		// adjustment saturates the length, so the block discards from here on
		load_setup(4'd15, 4'd15, 32'h7fff_ffff, 32'd0, '1, 1'b1);
		for (int i = 0; i < 8; i++) queue_byte(8'($urandom));
		for (int i = 0; i < 8; i++) queue_byte(8'hff);
		queue_byte(8'($urandom));
		queue_byte(8'($urandom));
		drain();

		if (errors == 0) begin
			$display("tb_length_field_frame_deframer_core OK");
		end else begin
			$display("tb_length_field_frame_deframer_core NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
src/lffd_pkg.sv
src/lffd_if.sv
src/lffd_datapath.sv
src/lffd_ctrl.sv
src/length_field_frame_deframer_core.sv
tb/tb_length_field_frame_deframer_core.sv
